>>> rtl/sia_pkg.sv
// Package for the script integer ALU: transaction types and opcodes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sia_pkg;

    typedef enum logic [4:0] {
        OP_PASS = 5'd0,
        OP_ADD = 5'd1,
        OP_SUB = 5'd2,
        OP_MUL = 5'd3,
        OP_DIV = 5'd4,
        OP_MOD = 5'd5,
        OP_POW = 5'd6,
        OP_AND = 5'd7,
        OP_OR  = 5'd8,
        OP_XOR = 5'd9,
        OP_SHL = 5'd10,
        OP_SHR = 5'd11,
        OP_EQ  = 5'd12,
        OP_LT  = 5'd13,
        OP_LE  = 5'd14,
        OP_GT  = 5'd15,
        OP_GE  = 5'd16,
        OP_NE  = 5'd17
    } op_t;

    typedef struct packed {
        logic signed [31:0] first_operand;
        logic [4:0]         opcode;
        logic signed [31:0] second_operand;
    } sia_in_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               zero_divisor;
    } sia_out_t;

endpackage
`default_nettype wire

>>> rtl/script_integer_alu_unit.sv
// Top level of the script integer ALU: sequencer, shared iterative unit, output register.
// Depends on sia_pkg.
`timescale 1ns / 1ps
`default_nettype none
// 32-bit signed ALU with one result per transaction. Simple operations (add, sub,
// logic, shifts, compares, pass, zero-divisor and power special cases) go from
// ST_IDLE through ST_EVAL to ST_DONE. Multiply, divide, modulo and power use one shared
// iteration unit that does one step per cycle for 32 steps (a radix-2 restoring
// divider step, or one add-and-shift multiply step); multiply, divide and modulo
// pass through ST_ITER and ST_FIX. Power runs 32 square-and-multiply rounds: a set
// exponent bit takes a multiply pass and a square pass, a clear bit a square pass only.
// in_ready is low while an item is in work or its result waits.
module script_integer_alu_unit
    import sia_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire sia_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output sia_out_t      out_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EVAL = 5'b00010,
        ST_ITER = 5'b00100,
        ST_FIX  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        K_MUL = 2'd0,
        K_DIV = 2'd1,
        K_PSQ = 2'd2,
        K_PML = 2'd3
    } kind_t;

    state_t      state_reg, state_next;
    kind_t       kind_reg, kind_next;
    logic [31:0] a_reg, a_next, b_reg, b_next;
    logic [4:0]  op_reg, op_next;
    logic [31:0] x_reg, x_next;      // multiplicand / divisor magnitude / base
    logic [31:0] y_reg, y_next;      // multiplier / dividend shift reg and quotient
    logic [31:0] acc_reg, acc_next;  // remainder / power accumulator
    logic [31:0] pr_reg, pr_next;    // partial product
    logic [5:0]  cnt_reg, cnt_next;  // iteration count within a pass
    logic [5:0]  rnd_reg, rnd_next;  // power rounds left
    sia_out_t    res_reg, res_next;

    logic [31:0] mag_a, mag_b;
    logic [32:0] trial;
    logic        slt_ab, slt_ba;

    assign mag_a  = a_reg[31] ? (32'd0 - a_reg) : a_reg;
    assign mag_b  = b_reg[31] ? (32'd0 - b_reg) : b_reg;
    assign slt_ab = $signed(a_reg) < $signed(b_reg);
    assign slt_ba = $signed(b_reg) < $signed(a_reg);
    assign trial  = {acc_reg, y_reg[31]} - {1'b0, x_reg};

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign out_data  = res_reg;

    // sequencer and shared step unit
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        op_next    = op_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        pr_next    = pr_reg;
        cnt_next   = cnt_reg;
        rnd_next   = rnd_reg;
        res_next   = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    a_next     = in_data.first_operand;
                    b_next     = in_data.second_operand;
                    op_next    = in_data.opcode;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                res_next.zero_divisor = 1'b0;
                res_next.result_value = a_reg;
                cnt_next   = 6'd0;
                state_next = ST_DONE;
                case (op_reg)
                    OP_ADD: res_next.result_value = a_reg + b_reg;
                    OP_SUB: res_next.result_value = a_reg - b_reg;
                    OP_AND: res_next.result_value = a_reg & b_reg;
                    OP_OR:  res_next.result_value = a_reg | b_reg;
                    OP_XOR: res_next.result_value = a_reg ^ b_reg;
                    OP_SHL: res_next.result_value = (b_reg[31:5] == 27'd0) ?
                                                    (a_reg << b_reg[4:0]) : 32'd0;
                    OP_SHR: res_next.result_value = (b_reg[31:5] == 27'd0) ?
                                                    (a_reg >> b_reg[4:0]) : 32'd0;
                    OP_EQ:  res_next.result_value = {31'd0, a_reg == b_reg};
                    OP_LT:  res_next.result_value = {31'd0, slt_ab};
                    OP_LE:  res_next.result_value = {31'd0, !slt_ba};
                    OP_GT:  res_next.result_value = {31'd0, slt_ba};
                    OP_GE:  res_next.result_value = {31'd0, !slt_ab};
                    OP_NE:  res_next.result_value = {31'd0, a_reg != b_reg};
                    OP_MUL:
                    begin
                        kind_next  = K_MUL;
                        x_next     = a_reg;
                        y_next     = b_reg;
                        acc_next   = 32'd0;
                        pr_next    = 32'd0;
                        state_next = ST_ITER;
                    end
                    OP_DIV, OP_MOD:
                    begin
                        if (b_reg == 32'd0)
                        begin
                            res_next.result_value = 32'd0;
                            res_next.zero_divisor = 1'b1;
                        end
                        else
                        begin
                            kind_next  = K_DIV;
                            x_next     = mag_b;
                            y_next     = mag_a;
                            acc_next   = 32'd0;
                            state_next = ST_ITER;
                        end
                    end
                    OP_POW:
                    begin
                        if (a_reg == 32'd0)
                            res_next.result_value = 32'd0;
                        else if (a_reg == 32'd1)
                            res_next.result_value = 32'd1;
                        else if (b_reg[31])
                            res_next.result_value = (a_reg == 32'hFFFF_FFFF) ?
                                (b_reg[0] ? 32'hFFFF_FFFF : 32'd1) : 32'd0;
                        else
                        begin
                            // acc holds power result; pr holds base
                            acc_next   = 32'd1;
                            pr_next    = a_reg;
                            rnd_next   = 6'd32;
                            state_next = ST_FIX;
                        end
                    end
                    default: ;
                endcase
            end
            ST_ITER:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (kind_reg == K_DIV)
                begin
                    y_next = {y_reg[30:0], 1'b0};
                    if (!trial[32])
                        acc_next = trial[31:0];
                    else
                        acc_next = {acc_reg[30:0], y_reg[31]};
                    // quotient bit goes into low bit of the shifting dividend
                    y_next[0] = !trial[32];
                end
                else
                begin
                    // add-and-shift multiply: pr += x if y lsb
                    if (y_reg[0])
                        pr_next = pr_reg + x_reg;
                    x_next = {x_reg[30:0], 1'b0};
                    y_next = {1'b0, y_reg[31:1]};
                end
                if (cnt_reg == 6'd31)
                    state_next = ST_FIX;
            end
            ST_FIX:
            begin
                unique case (kind_reg)
                    K_MUL:
                    begin
                        res_next.result_value = pr_reg;
                        state_next = ST_DONE;
                    end
                    K_DIV:
                    begin
                        if (op_reg == OP_DIV)
                            res_next.result_value = (a_reg[31] ^ b_reg[31]) ?
                                (32'd0 - y_reg) : y_reg;
                        else
                            res_next.result_value = a_reg[31] ?
                                (32'd0 - acc_reg) : acc_reg;
                        state_next = ST_DONE;
                    end
                    K_PSQ:
                    begin
                        // squaring finished: new base
                        pr_next   = pr_reg;
                        state_next = ST_FIX;
                    end
                    K_PML:
                    begin
                        state_next = ST_FIX;
                    end
                    default: ;
                endcase
                if (op_reg == OP_POW)
                begin
                    // power round control; b_reg holds remaining exponent
                    // x_reg/y_reg/pr_reg are reused by the multiply step
                    if (state_reg == ST_FIX && kind_reg == K_PML && cnt_reg == 6'd32)
                    begin
                        acc_next = pr_reg;   // acc *= base done
                        pr_next  = 32'd0;
                        x_next   = a_reg;
                        y_next   = a_reg;
                        kind_next = K_PSQ;
                        cnt_next = 6'd0;
                        state_next = ST_ITER;
                    end
                    else if (kind_reg == K_PSQ && cnt_reg == 6'd32)
                    begin
                        a_next   = pr_reg;   // base squared
                        b_next   = {1'b0, b_reg[31:1]};
                        rnd_next = rnd_reg - 6'd1;
                        cnt_next = 6'd0;
                        kind_next = K_MUL;
                        state_next = ST_FIX;
                        if (rnd_reg == 6'd1)
                        begin
                            res_next.result_value = acc_reg;
                            res_next.zero_divisor = 1'b0;
                            state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        // start of a round: multiply acc by base if exponent lsb
                        x_next   = a_reg;
                        y_next   = b_reg[0] ? acc_reg : 32'd0;
                        pr_next  = 32'd0;
                        cnt_next = 6'd0;
                        kind_next = K_PML;
                        state_next = ST_ITER;
                        if (!b_reg[0])
                        begin
                            // skip: multiply result must keep acc
                            x_next   = a_reg;
                            y_next   = a_reg;
                            kind_next = K_PSQ;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        // first entry into power: base lives in a_reg, exponent in b_reg
        if (state_reg == ST_EVAL && op_reg == OP_POW)
            kind_next = K_MUL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= K_MUL;
            cnt_reg   <= 6'd0;
            rnd_reg   <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            cnt_reg   <= cnt_next;
            rnd_reg   <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        op_reg  <= op_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        pr_reg  <= pr_next;
        res_reg <= res_next;
    end

`ifndef SYNTH
    a_busy_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("ready while busy");
    a_zd_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.zero_divisor) |-> (out_data.result_value == 32'd0))
        else $error("zero divisor result not zero");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result changed while stalled");
`endif

endmodule
`default_nettype wire
